FILE: hdl/dsa_pkg.sv
// Shared constants, types and helper functions of the Debye pair-sum accumulator.
package dsa_pkg;

	localparam int CORDIC_ITER_DEF = 24;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 48;

	localparam logic [CFG_IDX_W-1:0] REG_SCATTER_Q = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ = 2'd1;

	localparam logic [15:0] SCATTER_Q_RESET = 16'd4096;

	typedef logic signed [33:0] angle_t;

	localparam angle_t TWO_PI_Q30  = 34'sd6746518852;
	localparam angle_t PI_Q30      = 34'sd3373259426;
	localparam angle_t HALF_PI_Q30 = 34'sd1686629713;
	localparam angle_t GAIN_Q30    = 34'sd652032874;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam logic signed [49:0] SUM_MAX = 50'sd140737488355327;
	localparam logic signed [49:0] SUM_MIN = -50'sd140737488355328;

	function automatic angle_t atan_q30(input logic [5:0] idx);
		angle_t r;
		r = '0;
		unique case (idx)
			6'd0: r = 34'sd843314857;
			6'd1: r = 34'sd497837829;
			6'd2: r = 34'sd263043837;
			6'd3: r = 34'sd133525159;
			6'd4: r = 34'sd67021687;
			6'd5: r = 34'sd33543516;
			6'd6: r = 34'sd16775851;
			6'd7: r = 34'sd8388437;
			6'd8: r = 34'sd4194283;
			6'd9: r = 34'sd2097149;
			default: begin
				if (idx <= 6'd30) begin
					r = angle_t'(34'sd1 <<< (6'd30 - idx));
				end
			end
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/dsa_if.sv
// Channel interfaces for atom pairs, results and configuration writes.
interface dsa_pair_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] delta_x;
	logic signed [23:0] delta_y;
	logic signed [23:0] delta_z;
	logic [15:0]        weight_first;
	logic [15:0]        weight_second;
	logic               last_pair;
	modport source (output valid, delta_x, delta_y, delta_z, weight_first, weight_second,
		last_pair, input ready);
	modport sink (input valid, delta_x, delta_y, delta_z, weight_first, weight_second,
		last_pair, output ready);
endinterface

interface dsa_result_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] intensity_sum;
	logic [15:0]        pairs_within_cutoff;
	modport source (output valid, intensity_sum, pairs_within_cutoff, input ready);
	modport sink (input valid, intensity_sum, pairs_within_cutoff, output ready);
endinterface

interface dsa_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/dsa_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module dsa_isqrt
	import dsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] radicand,
	output logic        done,
	output logic [23:0] root
);
	logic [47:0] rad_q;
	logic [25:0] rem_q;
	logic [23:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [27:0] rem_t;
	logic [27:0] trial;

	assign rem_t = {rem_q, rad_q[47:46]};
	assign trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rad_q <= {rad_q[45:0], 2'b00};
				if (rem_t >= trial) begin
					rem_q  <= 26'(rem_t - trial);
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q  <= 26'(rem_t);
					root_q <= {root_q[22:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

FILE: hdl/dsa_cordic.sv
// Rotation-mode CORDIC sine, one micro-rotation per cycle.
module dsa_cordic
	import dsa_pkg::*;
#(
	parameter int ITERATIONS = CORDIC_ITER_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  angle_t angle,
	output logic   done,
	output angle_t sine
);
	localparam int IW = $clog2(ITERATIONS + 1);

	angle_t         cx_q;
	angle_t         cy_q;
	angle_t         z_q;
	logic [IW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	angle_t         ddx;
	angle_t         ddy;
	angle_t         step_t;

	assign ddx    = cy_q >>> cnt_q;
	assign ddy    = cx_q >>> cnt_q;
	assign step_t = atan_q30(6'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				cx_q   <= GAIN_Q30;
				cy_q   <= '0;
				z_q    <= angle;
			end else if (busy_q) begin
				if (!z_q[33]) begin
					cx_q <= cx_q - ddx;
					cy_q <= cy_q + ddy;
					z_q  <= z_q - step_t;
				end else begin
					cx_q <= cx_q + ddx;
					cy_q <= cy_q - ddy;
					z_q  <= z_q + step_t;
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == IW'(ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign sine = cy_q;
endmodule

FILE: hdl/dsa_div.sv
// Bit-serial restoring divider giving the sinc magnitude, clamped to one.
module dsa_div
	import dsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] mag,
	input  logic [39:0] den,
	output logic        done,
	output logic [30:0] quot
);
	logic [39:0] r_q;
	logic [39:0] den_q;
	logic [30:0] low_q;
	logic [30:0] q_q;
	logic        ovf_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [40:0] r_t;

	assign r_t = {r_q, low_q[30]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				den_q  <= den;
				ovf_q  <= {15'd0, mag[31:7]} >= den;
				r_q    <= {15'd0, mag[31:7]};
				low_q  <= {mag[6:0], 24'd0};
				q_q    <= '0;
			end else if (busy_q) begin
				low_q <= {low_q[29:0], 1'b0};
				if (r_t >= {1'b0, den_q}) begin
					r_q <= 40'(r_t - {1'b0, den_q});
					q_q <= {q_q[29:0], 1'b1};
				end else begin
					r_q <= 40'(r_t);
					q_q <= {q_q[29:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = (ovf_q || q_q > ONE_Q30) ? ONE_Q30 : q_q;
endmodule

FILE: hdl/debye_pair_sinc_accumulator.sv
// Top level of the Debye pair-sum accumulator with its sequencer and accumulator.
// Atom pairs arrive on pair_in, one transfer per pair; results leave on result_out.
// Configuration writes arrive on cfg: index 0 sets scatter_q, index 1 sets cutoff_sq,
// any other index is ignored. cfg is always ready and must only be written while idle.
// A pair outside the in-plane cutoff passes only through the squares and the cutoff
// check. A pair inside also runs the bit-serial square root, angle reduction, the
// CORDIC sine and the bit-serial divide, plus the squares, multiplications and accumulation.
// A zero argument gives a sinc of one and a small argument a quadratic approximation;
// both skip the sine and divide. Only one pair is in work at a time; pair_in is ready
// again once the pair has been folded into the sum.
// A pair marked last loads the sum and count into the output register and clears the
// accumulator. The next pair is accepted while that result still waits; if another
// last pair completes before the receiver takes the first result, the block holds
// until the output register is free. Reset clears the accumulator, the output valid
// and the registers to scatter_q = 1.0 and cutoff_sq = 0.
module debye_pair_sinc_accumulator
	import dsa_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input logic          clk,
	input logic          arst_n,
	dsa_pair_if.sink     pair_in,
	dsa_result_if.source result_out,
	dsa_cfg_if.sink      cfg
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_CHK, ST_SQRT, ST_MULQ, ST_SMALL, ST_REDUCE, ST_FOLD,
		ST_CORD, ST_DIV, ST_WMUL1, ST_WMUL2, ST_ACC, ST_FIN
	} state_t;

	state_t             state_q;
	logic [15:0]        scatter_q_q;
	logic [47:0]        cutoff_sq_q;
	logic signed [23:0] dx_q, dy_q, dz_q;
	logic [15:0]        wf_q, ws_q;
	logic               last_q;
	logic [1:0]         sq_cnt_q;
	logic [47:0]        r2_q, plane_q;
	logic [39:0]        x_q;
	logic [46:0]        a_q, d_q;
	logic [3:0]         k_q;
	angle_t             angle_q;
	logic [31:0]        mag_q;
	logic [30:0]        smag_q;
	logic               sneg_q;
	logic [31:0]        wprod_q;
	logic [62:0]        tprod_q;
	logic signed [47:0] sum_q;
	logic [15:0]        cnt_q;
	logic signed [47:0] res_sum_q;
	logic [15:0]        res_cnt_q;
	logic               out_valid_q;
	logic               sqrt_go_q, cord_go_q, div_go_q;

	logic               sqrt_done, cord_done, div_done;
	logic [23:0]        root;
	angle_t             sine;
	logic [30:0]        quot;
	logic signed [23:0] sq_op;
	logic [47:0]        sq;
	logic [23:0]        xsq;
	logic [11:0]        d6;
	angle_t             a_s, a_w, a_f;
	logic signed [49:0] term, ns;
	logic               out_free;
	logic               out_load;

	always_comb begin
		unique case (sq_cnt_q)
			2'd0:    sq_op = dx_q;
			2'd1:    sq_op = dy_q;
			default: sq_op = dz_q;
		endcase
	end
	assign sq  = 48'(sq_op * sq_op);
	assign xsq = x_q[11:0] * x_q[11:0];
	assign d6  = xsq[23:18] * 6'd43;

	always_comb begin
		a_s = {1'b0, a_q[32:0]};
		a_w = (a_s > PI_Q30) ? a_s - TWO_PI_Q30 : a_s;
		if (a_w > HALF_PI_Q30) begin
			a_f = PI_Q30 - a_w;
		end else if (a_w < -HALF_PI_Q30) begin
			a_f = -PI_Q30 - a_w;
		end else begin
			a_f = a_w;
		end
	end

	assign term = sneg_q ? -$signed({9'd0, tprod_q[61:21]}) : $signed({9'd0, tprod_q[61:21]});
	assign ns   = 50'(sum_q) + term;
	assign out_free = !out_valid_q || result_out.ready;
	assign out_load = (state_q == ST_FIN) && last_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scatter_q_q <= SCATTER_Q_RESET;
			cutoff_sq_q <= '0;
		end else if (cfg.valid) begin
			priority if (cfg.index == REG_SCATTER_Q) begin
				scatter_q_q <= cfg.data[15:0];
			end else if (cfg.index == REG_CUTOFF_SQ) begin
				cutoff_sq_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			sqrt_go_q   <= 1'b0;
			cord_go_q   <= 1'b0;
			div_go_q    <= 1'b0;
		end else begin
			sqrt_go_q <= 1'b0;
			cord_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			priority if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pair_in.valid) begin
						dx_q     <= pair_in.delta_x;
						dy_q     <= pair_in.delta_y;
						dz_q     <= pair_in.delta_z;
						wf_q     <= pair_in.weight_first;
						ws_q     <= pair_in.weight_second;
						last_q   <= pair_in.last_pair;
						sq_cnt_q <= '0;
						state_q  <= ST_SQ;
					end
				end
				ST_SQ: begin
					sq_cnt_q <= sq_cnt_q + 2'd1;
					if (sq_cnt_q == 2'd0) begin
						r2_q <= sq;
					end else begin
						r2_q <= r2_q + sq;
					end
					if (sq_cnt_q == 2'd2) begin
						plane_q <= r2_q;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (plane_q < cutoff_sq_q) begin
						sqrt_go_q <= 1'b1;
						state_q   <= ST_SQRT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						x_q     <= scatter_q_q * root;
						state_q <= ST_MULQ;
					end
				end
				ST_MULQ: begin
					sneg_q <= 1'b0;
					if (x_q == '0) begin
						smag_q  <= ONE_Q30;
						state_q <= ST_WMUL1;
					end else if (x_q < 40'd4096) begin
						state_q <= ST_SMALL;
					end else begin
						a_q     <= {1'b0, x_q, 6'd0};
						d_q     <= 47'(TWO_PI_Q30) << 13;
						k_q     <= 4'd13;
						state_q <= ST_REDUCE;
					end
				end
				ST_SMALL: begin
					smag_q  <= ONE_Q30 - {27'd0, d6[11:8]};
					state_q <= ST_WMUL1;
				end
				ST_REDUCE: begin
					if (a_q >= d_q) begin
						a_q <= a_q - d_q;
					end
					d_q <= d_q >> 1;
					k_q <= k_q - 4'd1;
					if (k_q == 4'd0) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					angle_q   <= a_f;
					cord_go_q <= 1'b1;
					state_q   <= ST_CORD;
				end
				ST_CORD: begin
					if (cord_done) begin
						sneg_q   <= sine[33];
						mag_q    <= sine[33] ? 32'(-sine) : 32'(sine);
						div_go_q <= 1'b1;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						smag_q  <= quot;
						state_q <= ST_WMUL1;
					end
				end
				ST_WMUL1: begin
					wprod_q <= wf_q * ws_q;
					state_q <= ST_WMUL2;
				end
				ST_WMUL2: begin
					tprod_q <= wprod_q * smag_q;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (ns > SUM_MAX) begin
						sum_q <= 48'(SUM_MAX);
					end else if (ns < SUM_MIN) begin
						sum_q <= 48'(SUM_MIN);
					end else begin
						sum_q <= 48'(ns);
					end
					if (cnt_q != 16'hFFFF) begin
						cnt_q <= cnt_q + 16'd1;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						res_sum_q <= sum_q;
						res_cnt_q <= cnt_q;
						sum_q     <= '0;
						cnt_q     <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	dsa_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_go_q),
		.radicand (r2_q),
		.done     (sqrt_done),
		.root     (root)
	);

	dsa_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_go_q),
		.angle  (angle_q),
		.done   (cord_done),
		.sine   (sine)
	);

	dsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.mag    (mag_q),
		.den    (x_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign pair_in.ready                  = (state_q == ST_IDLE);
	assign cfg.ready                      = 1'b1;
	assign result_out.valid               = out_valid_q;
	assign result_out.intensity_sum       = res_sum_q;
	assign result_out.pairs_within_cutoff = res_cnt_q;

	// A pair in work blocks the next transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		pair_in.valid && pair_in.ready |=> !pair_in.ready)
		else $error("pair accepted while another is in work");

	// A non-zero sum always comes with at least one counted pair.
	assert property (@(posedge clk) disable iff (!arst_n)
		sum_q != '0 |-> cnt_q != '0)
		else $error("sum non-zero with no counted pair");

	// Closing a sum publishes the result and clears the accumulator.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && last_q && out_free
		|=> result_out.valid && sum_q == '0 && cnt_q == '0)
		else $error("last pair did not publish and clear");

	// At most one arithmetic unit is started at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones({sqrt_go_q, cord_go_q, div_go_q}) <= 1)
		else $error("two arithmetic units started together");
endmodule
